/* sv/lcnps_pkg.sv */
// shared types and constants for the loop closure nearest pose search core
// no dependencies; used by the core, the store ram wrapper user and the checker
`default_nettype none

package lcnps_pkg;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INDEX_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE = 2'd2;

  // fixed field widths
  localparam int DIST_W    = 23;
  localparam int GAP_W     = 10;
  localparam int QIDX_W    = 10;
  localparam int LOOP_W    = 10;
  localparam int SQ_THR_W  = 2 * DIST_W;

  // reset values of the configuration registers
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST  = 23'd256;
  localparam logic [GAP_W-1:0]  MIN_INDEX_GAP_RST = 10'd30;
  localparam logic [DIST_W-1:0] NEAR_DISTANCE_RST = 23'd26;

  // item kind carried in the input tuser
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // result packing
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int OUT_FOUND_BIT    = 0;
  localparam int OUT_SIZE_ERR_BIT = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/lcnps_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lcnps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/loop_closure_nearest_pose_search_core.sv */
// loop closure nearest pose search: pose store with a linear nearest-candidate scan
// depends on lcnps_pkg and lcnps_ram
//
// usage
//   input stream (s_*): one transfer is either an append (tuser = 0) that stores a
//   pose at the next free entry, or a query (tuser = 1) that searches the store
//   for a loop candidate. appends to a full store are dropped.
//   output stream (m_*): one transfer per query, none per append.
//   config channel (cfg_*): register writes, taken in any cycle, only to be
//   issued while the core is idle; indexes beyond the register list are ignored.
// operation
//   an append is taken while idle; s_tready stays high after it.
//   a query scans n = start + 1 entries, one per cycle, through the store ram
//   read port (one read per cycle sets the rate), followed by a distance pipeline
//   (ram data, abs differences, squares, compare); the result reaches m_tvalid once
//   the last entry has left the pipeline, sooner on a near hit, which ends the
//   scan, and straight from the query when there is nothing to scan.
// reset
//   rst (synchronous) empties the store and loads the register reset values;
//   store contents are not cleared, entries are only read once written.
// stalls
//   a result waits in the output register while m_tready is low; the core
//   still takes new transfers, and a finished query holds until the output frees.
`default_nettype none

module loop_closure_nearest_pose_search_core #(
  parameter int STORE_DEPTH = 1024,
  parameter int COORD_WIDTH = 24,
  localparam int IN_DATA_W = ((2 * COORD_WIDTH + lcnps_pkg::QIDX_W + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tdata, low bit up: pos_x, pos_y, query_index, zero fill
  input  wire logic [IN_DATA_W-1:0]             s_tdata,
  // tuser: func
  input  wire logic                             s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // tdata, low bit up: loop_index, zero fill
  output logic [lcnps_pkg::OUT_DATA_W-1:0]      m_tdata,
  // tuser, low bit up: found, size_error
  output logic [lcnps_pkg::OUT_USER_W-1:0]      m_tuser,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lcnps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcnps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  // scan index width: wide enough for the store count and for a 10 bit frame index
  localparam int CMP_W  = (CNT_W > lcnps_pkg::QIDX_W) ? CNT_W : lcnps_pkg::QIDX_W;
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int CW     = (SUM_W > lcnps_pkg::SQ_THR_W) ? SUM_W : lcnps_pkg::SQ_THR_W;

  // ---------------------------------------------------------------------------
  // configuration registers and squared thresholds
  // ---------------------------------------------------------------------------
  logic [lcnps_pkg::DIST_W-1:0]   max_distance;
  logic [lcnps_pkg::GAP_W-1:0]    min_index_gap;
  logic [lcnps_pkg::DIST_W-1:0]   near_distance;
  logic [lcnps_pkg::SQ_THR_W-1:0] near2;
  logic [lcnps_pkg::SQ_THR_W-1:0] max2;
  logic [lcnps_pkg::SQ_THR_W-1:0] near2_next;
  logic [lcnps_pkg::SQ_THR_W-1:0] max2_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance  <= lcnps_pkg::MAX_DISTANCE_RST;
      min_index_gap <= lcnps_pkg::MIN_INDEX_GAP_RST;
      near_distance <= lcnps_pkg::NEAR_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcnps_pkg::REG_MAX_DISTANCE:  max_distance  <= cfg_data[lcnps_pkg::DIST_W-1:0];
        lcnps_pkg::REG_MIN_INDEX_GAP: min_index_gap <= cfg_data[lcnps_pkg::GAP_W-1:0];
        lcnps_pkg::REG_NEAR_DISTANCE: near_distance <= cfg_data[lcnps_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // squares follow the registers in the next cycle, well before any compare needs them
  assign near2_next = near_distance * near_distance;
  assign max2_next  = max_distance * max_distance;

  always_ff @(posedge clk) begin
    near2 <= near2_next;
    max2  <= max2_next;
  end

  // ---------------------------------------------------------------------------
  // input field split
  // ---------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0]       in_x;
  logic [COORD_WIDTH-1:0]       in_y;
  logic [lcnps_pkg::QIDX_W-1:0] in_qidx;

  assign in_x    = s_tdata[COORD_WIDTH-1:0];
  assign in_y    = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign in_qidx = s_tdata[2*COORD_WIDTH+lcnps_pkg::QIDX_W-1:2*COORD_WIDTH];

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  lcnps_pkg::state_t state;
  lcnps_pkg::state_t state_next;

  logic [CNT_W-1:0]  count;
  logic [CMP_W-1:0]  scan_idx;
  logic              issue_active;
  logic              p1_valid;
  logic              p2_valid;
  logic              p3_valid;

  logic              in_fire;
  logic              is_query;
  logic              store_full;
  logic              size_err;
  logic              no_scan;
  logic [lcnps_pkg::QIDX_W-1:0] start_raw;
  logic [CMP_W-1:0]  start_ext;
  logic [CMP_W-1:0]  last_ext;
  logic [CMP_W-1:0]  start;
  logic              issue_fire;
  logic              pipe_busy;
  logic              near_hit;
  logic              best_hit;
  logic              kill;
  logic              out_free;

  assign s_tready   = (state == lcnps_pkg::ST_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign is_query   = (s_tuser == lcnps_pkg::FUNC_QUERY);
  assign store_full = (count == CNT_W'(STORE_DEPTH));

  // query set-up: size check, negative start, clamp to the last stored entry
  assign size_err  = CMP_W'(count) < CMP_W'(min_index_gap);
  assign no_scan   = (in_qidx < min_index_gap) || (count == '0);
  assign start_raw = in_qidx - min_index_gap;
  assign start_ext = CMP_W'(start_raw);
  assign last_ext  = CMP_W'(count) - CMP_W'(1);
  assign start     = (start_ext > last_ext) ? last_ext : start_ext;

  assign pipe_busy  = p1_valid || p2_valid || p3_valid;
  assign kill       = p3_valid && near_hit;
  assign issue_fire = (state == lcnps_pkg::ST_SCAN) && issue_active && !kill;
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      lcnps_pkg::ST_IDLE: begin
        if (in_fire && is_query) begin
          state_next = (size_err || no_scan) ? lcnps_pkg::ST_DONE : lcnps_pkg::ST_SCAN;
        end
      end
      lcnps_pkg::ST_SCAN: begin
        if (kill || (!issue_active && !pipe_busy)) begin
          state_next = lcnps_pkg::ST_DONE;
        end
      end
      lcnps_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lcnps_pkg::ST_IDLE;
        end
      end
      default: state_next = lcnps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcnps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // pose store
  // ---------------------------------------------------------------------------
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [IDX_W-1:0]       rd_addr;
  logic [COORD_WIDTH-1:0] rd_x;
  logic [COORD_WIDTH-1:0] rd_y;

  // appends only happen while idle, so a write never meets a scan read
  assign wr_en   = in_fire && !is_query && !store_full;
  assign wr_addr = count[IDX_W-1:0];
  assign rd_addr = scan_idx[IDX_W-1:0];

  lcnps_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_x_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_x),
    .rd_en   (issue_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_x)
  );

  lcnps_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_y_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_y),
    .rd_en   (issue_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // scan pipeline: issue -> ram data -> abs differences -> squares -> compare
  // ---------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0]       qx;
  logic [COORD_WIDTH-1:0]       qy;
  logic [lcnps_pkg::LOOP_W-1:0] p1_idx;
  logic [lcnps_pkg::LOOP_W-1:0] p2_idx;
  logic [lcnps_pkg::LOOP_W-1:0] p3_idx;
  logic [MAG_W-1:0]             diff_x;
  logic [MAG_W-1:0]             diff_y;
  logic [MAG_W-1:0]             p2_dx;
  logic [MAG_W-1:0]             p2_dy;
  logic [SQ_W-1:0]              p3_sqx;
  logic [SQ_W-1:0]              p3_sqy;
  logic [SUM_W-1:0]             d2;
  logic [lcnps_pkg::SQ_THR_W-1:0] best2;
  logic [lcnps_pkg::SQ_THR_W-1:0] thr;
  logic                         res_found;
  logic [lcnps_pkg::LOOP_W-1:0] res_index;
  logic                         res_size_err;

  // sign-extended differences, one bit wider so the magnitude always fits
  assign diff_x = {rd_x[COORD_WIDTH-1], rd_x} - {qx[COORD_WIDTH-1], qx};
  assign diff_y = {rd_y[COORD_WIDTH-1], rd_y} - {qy[COORD_WIDTH-1], qy};

  assign d2       = SUM_W'(p3_sqx) + SUM_W'(p3_sqy);
  // until a candidate is held the bar is the maximum distance
  assign thr      = res_found ? best2 : max2;
  assign near_hit = CW'(d2) < CW'(near2);
  assign best_hit = CW'(d2) < CW'(thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
    end else begin
      if (in_fire && is_query) begin
        issue_active <= !(size_err || no_scan);
      end else if (kill) begin
        issue_active <= 1'b0;
      end else if (issue_fire && (scan_idx == '0)) begin
        issue_active <= 1'b0;
      end
      p1_valid <= issue_fire;
      p2_valid <= p1_valid && !kill;
      p3_valid <= p2_valid && !kill;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      qx       <= in_x;
      qy       <= in_y;
      scan_idx <= start;
    end else if (issue_fire) begin
      scan_idx <= scan_idx - CMP_W'(1);
    end
    p1_idx <= scan_idx[lcnps_pkg::LOOP_W-1:0];
    p2_idx <= p1_idx;
    p2_dx  <= diff_x[MAG_W-1] ? (~diff_x + MAG_W'(1)) : diff_x;
    p2_dy  <= diff_y[MAG_W-1] ? (~diff_y + MAG_W'(1)) : diff_y;
    p3_idx <= p2_idx;
    p3_sqx <= p2_dx * p2_dx;
    p3_sqy <= p2_dy * p2_dy;
  end

  // ---------------------------------------------------------------------------
  // result held until the output register is free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_found <= 1'b0;
    end else if (in_fire && is_query) begin
      res_found <= 1'b0;
    end else if (p3_valid && (near_hit || best_hit)) begin
      res_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      res_index    <= '0;
      res_size_err <= size_err;
    end else if (p3_valid && (near_hit || best_hit)) begin
      res_index <= p3_idx;
    end
    // first strictly closer entry keeps the bar, so ties stay with the higher index
    if (p3_valid && !near_hit && best_hit) begin
      best2 <= lcnps_pkg::SQ_THR_W'(d2);
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                         out_load;
  logic                         out_found;
  logic [lcnps_pkg::LOOP_W-1:0] out_index;
  logic                         out_size_err;

  assign out_load = (state == lcnps_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found    <= res_found;
      out_index    <= res_index;
      out_size_err <= res_size_err;
    end
  end

  assign m_tdata = lcnps_pkg::OUT_DATA_W'(out_index);
  always_comb begin
    m_tuser = '0;
    m_tuser[lcnps_pkg::OUT_FOUND_BIT]    = out_found;
    m_tuser[lcnps_pkg::OUT_SIZE_ERR_BIT] = out_size_err;
  end

endmodule

`default_nettype wire

/* sv/lcnps_checker.sv */
// port level checks for the loop closure nearest pose search core
// depends on lcnps_pkg; bound to loop_closure_nearest_pose_search_core below
`default_nettype none

module lcnps_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        s_tuser,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [lcnps_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [lcnps_pkg::OUT_USER_W-1:0] m_tuser
);

  // a query transfer always takes the core out of idle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == lcnps_pkg::FUNC_QUERY)) |=> !s_tready)
    else $error("input still ready after a query transfer");

  // an append leaves the input ready in the next cycle
  a_append_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == lcnps_pkg::FUNC_APPEND)) |=> s_tready)
    else $error("input not ready after an append transfer");

  // a size error never comes with a candidate
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[lcnps_pkg::OUT_FOUND_BIT] && m_tuser[lcnps_pkg::OUT_SIZE_ERR_BIT]))
    else $error("found and size error both set");

  // no candidate means index zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[lcnps_pkg::OUT_FOUND_BIT]) |-> (m_tdata == '0))
    else $error("non-zero loop index without a candidate");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind loop_closure_nearest_pose_search_core lcnps_checker u_lcnps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for loop_closure_nearest_pose_search_core
// depends on lcnps_pkg and the core; a scoreboard class predicts each query result
`default_nettype none

module tb_top;
  import lcnps_pkg::*;

  localparam int COORD_W     = 24;
  localparam int DEPTH       = 1024;
  localparam int IN_W        = 64;
  localparam int HOLD_CYCLES = 3000;

  localparam logic [COORD_W-1:0] COORD_MAX = 24'h7fffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 23'h7fffff;
  localparam logic [GAP_W-1:0]   GAP_MAX   = 10'd1023;
  localparam logic [QIDX_W-1:0]  QIDX_MAX  = 10'd1023;
  // register index past the end of the map
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

  // one query outcome as the core reports it
  typedef struct packed {
    logic              found;
    logic [LOOP_W-1:0] loop_index;
    logic              size_error;
  } loop_result_t;

  // keeps its own copy of the pose store and the registers, and the queue of
  // loop results still owed by the core
  class loop_search_checker;
    logic signed [COORD_W-1:0] pose_x [DEPTH];
    logic signed [COORD_W-1:0] pose_y [DEPTH];
    int unsigned               pose_count;
    logic [DIST_W-1:0]         max_dist;
    logic [DIST_W-1:0]         near_dist;
    logic [GAP_W-1:0]          index_gap;
    loop_result_t              expected_loops [$];

    function new();
      pose_count = 0;
      max_dist   = MAX_DISTANCE_RST;
      near_dist  = NEAR_DISTANCE_RST;
      index_gap  = MIN_INDEX_GAP_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_DISTANCE:  max_dist  = data[DIST_W-1:0];
        REG_MIN_INDEX_GAP: index_gap = data[GAP_W-1:0];
        REG_NEAR_DISTANCE: near_dist = data[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_loops.size();
    endfunction

    // scan from the start entry downwards; a near hit ends the scan, otherwise
    // the strictly closest entry under max_dist wins, the higher index on a tie
    function loop_result_t search_loop_candidate(logic signed [COORD_W-1:0] px,
                                                 logic signed [COORD_W-1:0] py,
                                                 logic [QIDX_W-1:0] qidx);
      loop_result_t res;
      longint dx, dy, d2, near_sq, best_sq;
      int start, i;
      bit done;
      res = '0;
      if (pose_count < index_gap) begin
        res.size_error = 1'b1;
      end else if (qidx >= index_gap && pose_count > 0) begin
        start   = int'(qidx) - int'(index_gap);
        if (start > int'(pose_count) - 1) start = int'(pose_count) - 1;
        near_sq = longint'(near_dist) * longint'(near_dist);
        best_sq = longint'(max_dist) * longint'(max_dist);
        done    = 1'b0;
        for (i = start; i >= 0 && !done; i--) begin
          dx = longint'(pose_x[i]) - longint'(px);
          dy = longint'(pose_y[i]) - longint'(py);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          d2 = dx * dx + dy * dy;
          if (d2 < near_sq) begin
            res.found      = 1'b1;
            res.loop_index = i[LOOP_W-1:0];
            done           = 1'b1;
          end else if (d2 < best_sq) begin
            res.found      = 1'b1;
            res.loop_index = i[LOOP_W-1:0];
            best_sq        = d2;
          end
        end
      end
      return res;
    endfunction

    function void take_item(logic func, logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py, logic [QIDX_W-1:0] qidx);
      if (func == FUNC_APPEND) begin
        if (pose_count < DEPTH) begin
          pose_x[pose_count] = px;
          pose_y[pose_count] = py;
          pose_count++;
        end
      end else begin
        expected_loops = {expected_loops, search_loop_candidate(px, py, qidx)};
      end
    endfunction

    // empty string when the result matches the oldest expectation
    function string match_result(loop_result_t got);
      loop_result_t want;
      string diffs;
      if (expected_loops.size() == 0)
        return $sformatf("unexpected result found=%0b loop_index=%0d size_error=%0b",
                         got.found, got.loop_index, got.size_error);
      want  = expected_loops.pop_front();
      diffs = "";
      if (got.found != want.found)
        diffs = {diffs, $sformatf(" found %0b want %0b", got.found, want.found)};
      if (got.loop_index != want.loop_index)
        diffs = {diffs, $sformatf(" loop_index %0d want %0d", got.loop_index,
                                  want.loop_index)};
      if (got.size_error != want.size_error)
        diffs = {diffs, $sformatf(" size_error %0b want %0b", got.size_error,
                                  want.size_error)};
      if (diffs.len() != 0) return {"result mismatch:", diffs};
      return "";
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // tdata, low bit up: pos_x, pos_y, query_index, zero fill
  logic [IN_W-1:0]       s_tdata = '0;
  // tuser: func
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // tdata, low bit up: loop_index, zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  // tuser, low bit up: found, size_error
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  loop_search_checker sb = new();
  int                 mismatches = 0;
  bit                 hold_req = 1'b0;
  int                 walk_x, walk_y;
  loop_result_t       seen;
  string              seen_msg;

  loop_closure_nearest_pose_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling: every item at its slowest, scans over the full store
  initial begin
    #100000000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] %s", $time, what);
  endtask

  // result side: every accepted transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.found      = m_tuser[OUT_FOUND_BIT];
      seen.size_error = m_tuser[OUT_SIZE_ERR_BIT];
      seen.loop_index = m_tdata[LOOP_W-1:0];
      seen_msg        = sb.match_result(seen);
      if (seen_msg.len() != 0) report_mismatch(seen_msg);
    end
  end

  // receiver stall pattern: modes change at random, with stretches
  // of steady readiness; on request one long hold-off so the core backs up
  initial begin : receiver
    int mode, left;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0:       m_tready = 1'b1;
        1:       m_tready = 1'($urandom_range(0, 1));
        2:       m_tready = ($urandom_range(0, 7) != 0);
        default: m_tready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // one input transfer; valid stays high so back-to-back items need no gap
  task automatic send_item(logic func, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [QIDX_W-1:0] qidx);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = {{(IN_W - 2 * COORD_W - QIDX_W){1'b0}}, qidx, y, x};
    do @(posedge clk); while (!s_tready);
    sb.take_item(func, x, y, qidx);
  endtask

  task automatic pause_input(int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(logic [DIST_W-1:0] max_d, logic [GAP_W-1:0] gap,
                                logic [DIST_W-1:0] near_d);
    write_reg(REG_MAX_DISTANCE, max_d);
    write_reg(REG_MIN_INDEX_GAP, CFG_DATA_W'(gap));
    write_reg(REG_NEAR_DISTANCE, near_d);
  endtask

  // drain every owed result, then let an append or an empty scan settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic append_walk_pose();
    walk_x = walk_x + int'($urandom_range(0, 400)) - 200;
    walk_y = walk_y + int'($urandom_range(0, 400)) - 200;
    send_item(FUNC_APPEND, walk_x[COORD_W-1:0], walk_y[COORD_W-1:0],
              QIDX_W'($urandom_range(0, 1023)));
  endtask

  // a query close to a stored pose, current index just past the store when deep, else low
  task automatic query_near_pose(bit deep);
    int t, amp, qx, qy, qi;
    amp = 16;
    case ($urandom_range(0, 2))
      0: amp = 16;
      1: amp = 160;
      default: amp = 2000;
    endcase
    if (sb.pose_count > 0) begin
      t  = $urandom_range(0, sb.pose_count - 1);
      qx = int'(sb.pose_x[t]) + int'($urandom_range(0, 2 * amp)) - amp;
      qy = int'(sb.pose_y[t]) + int'($urandom_range(0, 2 * amp)) - amp;
    end else begin
      qx = walk_x;
      qy = walk_y;
    end
    qi = deep ? int'(sb.pose_count) + int'($urandom_range(0, 40))
              : int'($urandom_range(0, 60));
    if (qi > 1023) qi = 1023;
    send_item(FUNC_QUERY, qx[COORD_W-1:0], qy[COORD_W-1:0], qi[QIDX_W-1:0]);
  endtask

  // mostly a trajectory with queries that revisit it, some raw noise
  task automatic random_phase(int n_items);
    int k, j, burst, r;
    k = 0;
    walk_x = int'($urandom_range(0, 16000000)) - 8000000;
    walk_y = int'($urandom_range(0, 16000000)) - 8000000;
    while (k < n_items) begin
      burst = $urandom_range(1, 12);
      for (j = 0; j < burst && k < n_items; j++) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          append_walk_pose();
        else if (r < 85)
          query_near_pose(1'b1);
        else if (r < 93)
          send_item(FUNC_QUERY, COORD_W'($urandom), COORD_W'($urandom),
                    QIDX_W'($urandom_range(0, 1023)));
        else
          send_item(FUNC_APPEND, COORD_W'($urandom), COORD_W'($urandom),
                    QIDX_W'($urandom_range(0, 1023)));
        k++;
      end
      pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end
  endtask

  initial begin : stimulus
    int j;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: register reset values, empty store gives a size error
    send_item(FUNC_QUERY, '0, '0, '0);
    wait_idle();
    // zero gap taken literally, and a write to an unknown register index
    write_reg(REG_MIN_INDEX_GAP, '0);
    write_reg(REG_UNKNOWN, CFG_DATA_W'($urandom));
    // zero gap on an empty store scans nothing
    send_item(FUNC_QUERY, '0, '0, 10'd5);
    // coordinate extremes and a duplicated pose for the tie rule
    send_item(FUNC_APPEND, '0, '0, QIDX_MAX);
    send_item(FUNC_APPEND, COORD_MAX, COORD_MAX, '0);
    send_item(FUNC_APPEND, COORD_MIN, COORD_MIN, QIDX_MAX);
    send_item(FUNC_APPEND, COORD_MAX, COORD_MIN, '0);
    send_item(FUNC_APPEND, COORD_MIN, COORD_MAX, 10'h155);
    send_item(FUNC_APPEND, 24'h000100, '0, 10'h2aa);
    send_item(FUNC_APPEND, 24'h000100, '0, '0);
    // start past the store is clamped; near hit on the last entry
    send_item(FUNC_QUERY, 24'h000100, 24'h000010, QIDX_MAX);
    // scan of entry zero only, far away
    send_item(FUNC_QUERY, COORD_MAX, COORD_MAX, '0);
    wait_idle();
    apply_settings(DIST_MAX, '0, '0);
    // equal distances: the higher index is scanned first and wins
    send_item(FUNC_QUERY, 24'h000120, '0, 10'd6);
    send_item(FUNC_QUERY, COORD_MIN, COORD_MIN, QIDX_MAX);
    send_item(FUNC_QUERY, COORD_MAX, COORD_MIN, QIDX_MAX);
    wait_idle();
    write_reg(REG_NEAR_DISTANCE, DIST_MAX);
    send_item(FUNC_QUERY, '0, '0, QIDX_MAX);
    wait_idle();
    apply_settings('0, GAP_MAX, '0);
    // store smaller than the gap
    send_item(FUNC_QUERY, '0, '0, QIDX_MAX);
    wait_idle();
    apply_settings('0, '0, '0);
    send_item(FUNC_QUERY, 24'h000100, '0, QIDX_MAX);
    wait_idle();
    apply_settings(MAX_DISTANCE_RST, 10'd3, NEAR_DISTANCE_RST);
    // query index below the gap scans nothing; one equal to the gap scans entry zero only
    send_item(FUNC_QUERY, '0, '0, 10'd1);
    send_item(FUNC_QUERY, '0, '0, 10'd3);
    wait_idle();

    // random phases over several register settings
    apply_settings(MAX_DISTANCE_RST, MIN_INDEX_GAP_RST, NEAR_DISTANCE_RST);
    hold_req = 1'b1;
    random_phase(100);
    wait_idle();
    apply_settings(DIST_MAX, 10'd1, '0);
    random_phase(100);
    wait_idle();
    apply_settings('0, GAP_W'($urandom_range(1, 20)), DIST_W'($urandom_range(0, 8388607)));
    random_phase(100);
    wait_idle();
    apply_settings(DIST_W'($urandom_range(100, 3000)), GAP_W'($urandom_range(2, 60)),
                   DIST_W'($urandom_range(0, 100)));
    random_phase(100);
    wait_idle();
    apply_settings(23'd1000, GAP_MAX, DIST_MAX);
    random_phase(40);
    wait_idle();
    apply_settings(DIST_W'($urandom_range(0, 8388607)), GAP_W'($urandom_range(1, 40)),
                   DIST_W'($urandom_range(0, 600)));
    random_phase(100);
    wait_idle();

    // closing queries over the whole accumulated store, deep and shallow
    apply_settings(23'd512, 10'd10, NEAR_DISTANCE_RST);
    for (j = 0; j < 3; j++) query_near_pose(1'b1);
    for (j = 0; j < 8; j++) query_near_pose(1'b0);

    // drain, allow for any late transfer, then give the verdict
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/lcnps_pkg.sv
sv/lcnps_ram.sv
sv/loop_closure_nearest_pose_search_core.sv
sv/lcnps_checker.sv
tb/tb_top.sv
